>>> rtl/wtm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wtm_pkg
// Shared constants and types of the winner-tree k-way merge.
// ============================================================================
package wtm_pkg;

    localparam int DEF_NUM_WAYS = 8;
    localparam int KEY_W        = 32;
    localparam int CMD_DEPTH    = 2;    // command queue depth, power of two

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIRST,
        ST_MATCH,
        ST_EMIT
    } back_state_t;

endpackage

>>> rtl/wtm_front.sv
`timescale 1ns / 1ps
// ============================================================================
// wtm_front
// Input side: drops transfers that name a way beyond the tree and packs the
// rest into commands for the queue.
// ============================================================================
module wtm_front #(
    parameter int NUM_WAYS = wtm_pkg::DEF_NUM_WAYS,
    localparam int WAY_W   = $clog2(NUM_WAYS),
    localparam int CMD_W   = 1 + WAY_W + wtm_pkg::KEY_W
) (
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [WAY_W-1:0]         way,
    input  logic [wtm_pkg::KEY_W-1:0] key,
    input  logic                     run_ended,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [CMD_W-1:0]         push_data
);

    logic in_range;

    assign in_range   = {1'b0, way} < (WAY_W+1)'(NUM_WAYS);
    assign item_ready = push_ready;
    assign push_valid = item_valid && in_range;
    assign push_data  = {run_ended, way, key};

endmodule

>>> rtl/wtm_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// wtm_fifo
// Short command queue between the front and the tree engine.
// ============================================================================
module wtm_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = wtm_pkg::CMD_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/wtm_back.sv
`timescale 1ns / 1ps
// ============================================================================
// wtm_back
// Tree engine: writes leaf heads, replays leaf-to-root matches over a node
// memory with one read and one write port, and holds the result register.
// ============================================================================
module wtm_back #(
    parameter int NUM_WAYS = wtm_pkg::DEF_NUM_WAYS,
    localparam int WAY_W   = $clog2(NUM_WAYS),
    localparam int KEY_W   = wtm_pkg::KEY_W,
    localparam int CMD_W   = 1 + WAY_W + KEY_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [KEY_W-1:0] winner_key,
    output logic [WAY_W-1:0] winner_way,
    output logic             done_res
);

    localparam int NODES  = 2 * NUM_WAYS;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NUM_WAYS + 1);
    localparam int ENT_W  = 1 + WAY_W + KEY_W;

    wtm_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0]    primed_reg, primed_next;
    logic [NUM_WAYS-1:0] leaf_ended_reg, leaf_ended_next;
    logic                build_reg, build_next;
    logic [WAY_W-1:0]    rw_reg, rw_next;
    logic [NODE_W-1:0]   cmp_reg, cmp_next;
    logic                cur_ended_reg, cur_ended_next;
    logic [WAY_W-1:0]    cur_way_reg, cur_way_next;
    logic [KEY_W-1:0]    cur_key_reg, cur_key_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [WAY_W-1:0]    out_way_reg, out_way_next;
    logic                out_done_reg, out_done_next;

    logic [ENT_W-1:0]    node_mem [NODES];
    logic [ENT_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic [NODE_W-1:0]   mem_waddr, mem_raddr;
    logic [ENT_W-1:0]    mem_wdata;

    logic                c_ended;
    logic [WAY_W-1:0]    c_way;
    logic [KEY_W-1:0]    c_key;
    logic                cmd_pop, out_free, emit_fire;
    logic [NODE_W-1:0]   leaf_node, sib, sib_off, parent;
    logic                sib_is_leaf, sib_ended, cur_wins, last_way, primed_full;
    logic [WAY_W-1:0]    sib_way;
    logic [KEY_W-1:0]    sib_key;

    function automatic logic beats(
        input logic             ea,
        input logic [KEY_W-1:0] ka,
        input logic [WAY_W-1:0] wa,
        input logic             eb,
        input logic [KEY_W-1:0] kb,
        input logic [WAY_W-1:0] wb
    );
        logic r;
        if (ea != eb)
            r = !ea;
        else if (ea)
            r = wa < wb;
        else if (ka != kb)
            r = $signed(ka) < $signed(kb);
        else
            r = wa < wb;
        return r;
    endfunction

    assign {c_ended, c_way, c_key} = cmd_data;

    assign cmd_ready   = state_reg == wtm_pkg::ST_IDLE;
    assign cmd_pop     = cmd_valid && cmd_ready;
    assign out_free    = !out_valid_reg || result_ready;
    assign emit_fire   = (state_reg == wtm_pkg::ST_EMIT) && out_free;
    assign primed_full = primed_reg == CNT_W'(NUM_WAYS);
    assign last_way    = rw_reg == WAY_W'(NUM_WAYS - 1);
    assign leaf_node   = NODE_W'(NUM_WAYS) + NODE_W'(rw_reg);

    assign sib         = cmp_reg ^ NODE_W'(1);
    assign sib_is_leaf = sib >= NODE_W'(NUM_WAYS);
    assign sib_off     = sib - NODE_W'(NUM_WAYS);
    assign sib_way     = sib_is_leaf ? sib_off[WAY_W-1:0] : rd_data_reg[KEY_W +: WAY_W];
    assign sib_ended   = sib_is_leaf ? leaf_ended_reg[sib_off[WAY_W-1:0]]
                                     : rd_data_reg[ENT_W-1];
    assign sib_key     = rd_data_reg[KEY_W-1:0];
    assign parent      = cmp_reg >> 1;
    assign cur_wins    = beats(cur_ended_reg, cur_key_reg, cur_way_reg,
                               sib_ended, sib_key, sib_way);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wtm_pkg::ST_IDLE:
            begin
                if (cmd_pop && (primed_full || primed_reg == CNT_W'(NUM_WAYS - 1)))
                    state_next = wtm_pkg::ST_LOAD;
            end
            wtm_pkg::ST_LOAD:  state_next = wtm_pkg::ST_FIRST;
            wtm_pkg::ST_FIRST: state_next = wtm_pkg::ST_MATCH;
            wtm_pkg::ST_MATCH:
            begin
                if (parent == NODE_W'(1))
                    state_next = (build_reg && !last_way) ? wtm_pkg::ST_LOAD
                                                          : wtm_pkg::ST_EMIT;
            end
            wtm_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = wtm_pkg::ST_IDLE;
            end
            default: state_next = wtm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        primed_next     = primed_reg;
        leaf_ended_next = leaf_ended_reg;
        build_next      = build_reg;
        rw_next         = rw_reg;
        cmp_next        = cmp_reg;
        cur_ended_next  = cur_ended_reg;
        cur_way_next    = cur_way_reg;
        cur_key_next    = cur_key_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_key_next    = out_key_reg;
        out_way_next    = out_way_reg;
        out_done_next   = out_done_reg;
        mem_we          = 1'b0;
        mem_waddr       = NODE_W'(NUM_WAYS) + NODE_W'(c_way);
        mem_wdata       = {1'b0, c_way, c_key};
        mem_raddr       = leaf_node;
        unique case (state_reg)
            wtm_pkg::ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    mem_we                 = !c_ended;
                    leaf_ended_next[c_way] = c_ended;
                    if (primed_full)
                    begin
                        build_next = 1'b0;
                        rw_next    = c_way;
                    end
                    else
                    begin
                        primed_next = primed_reg + 1'b1;
                        build_next  = 1'b1;
                        rw_next     = '0;
                    end
                end
            end
            wtm_pkg::ST_LOAD:
            begin
                mem_raddr = leaf_node;
            end
            wtm_pkg::ST_FIRST:
            begin
                cur_ended_next = leaf_ended_reg[rw_reg];
                cur_way_next   = rw_reg;
                cur_key_next   = rd_data_reg[KEY_W-1:0];
                cmp_next       = leaf_node;
                mem_raddr      = leaf_node ^ NODE_W'(1);
            end
            wtm_pkg::ST_MATCH:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                if (!cur_wins)
                begin
                    cur_ended_next = sib_ended;
                    cur_way_next   = sib_way;
                    cur_key_next   = sib_key;
                end
                mem_wdata = cur_wins ? {cur_ended_reg, cur_way_reg, cur_key_reg}
                                     : {sib_ended, sib_way, sib_key};
                cmp_next  = parent;
                mem_raddr = parent ^ NODE_W'(1);
                if (parent == NODE_W'(1) && build_reg && !last_way)
                    rw_next = rw_reg + 1'b1;
            end
            wtm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = cur_ended_reg;
                    out_key_next   = cur_ended_reg ? '0 : cur_key_reg;
                    out_way_next   = cur_ended_reg ? '0 : cur_way_reg;
                    if (cur_ended_reg)
                    begin
                        primed_next     = '0;
                        leaf_ended_next = '1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wtm_pkg::ST_IDLE;
            primed_reg     <= '0;
            leaf_ended_reg <= '1;
            build_reg      <= 1'b0;
            rw_reg         <= '0;
            cmp_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            primed_reg     <= primed_next;
            leaf_ended_reg <= leaf_ended_next;
            build_reg      <= build_next;
            rw_reg         <= rw_next;
            cmp_reg        <= cmp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ended_reg <= cur_ended_next;
        cur_way_reg   <= cur_way_next;
        cur_key_reg   <= cur_key_next;
        out_key_reg   <= out_key_next;
        out_way_reg   <= out_way_next;
        out_done_reg  <= out_done_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= node_mem[mem_raddr];
    end

    assign result_valid = out_valid_reg;
    assign winner_key   = out_key_reg;
    assign winner_way   = out_way_reg;
    assign done_res     = out_done_reg;

    a_done_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_key_reg == '0 && out_way_reg == '0)
        else $error("done result carries nonzero key or way");

    a_match_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wtm_pkg::ST_MATCH |-> cmp_reg >= NODE_W'(2))
        else $error("match step above the root");

    a_emit_primed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wtm_pkg::ST_EMIT |-> primed_full)
        else $error("result before all ways were primed");

    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && cur_ended_reg |=> primed_reg == '0 && (&leaf_ended_reg))
        else $error("tree not cleared after done");

endmodule

>>> rtl/winner_tree_kway_merge.sv
`timescale 1ns / 1ps
// ============================================================================
// winner_tree_kway_merge
// Winner-tree merge of NUM_WAYS sorted runs with a decoupled command queue.
// ============================================================================
// Each transfer writes one run's head key or marks it ended. The first
// NUM_WAYS-1 transfers prime the tree and return nothing; the next one builds
// the tree by replaying every leaf in turn and returns the first winner. After
// that each transfer returns the smallest live key and its way, found by one
// match per cycle up the leaf-to-root path, set by the single read port of
// the node memory. When every run is ended the result has done_res set and
// the block primes again. Up to two transfers queue ahead of the engine.
// ============================================================================
module winner_tree_kway_merge #(
    parameter int NUM_WAYS = wtm_pkg::DEF_NUM_WAYS,
    localparam int WAY_W   = $clog2(NUM_WAYS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [WAY_W-1:0]          way,
    input  logic [wtm_pkg::KEY_W-1:0] key,
    input  logic                      run_ended,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [wtm_pkg::KEY_W-1:0] winner_key,
    output logic [WAY_W-1:0]          winner_way,
    output logic                      done_res
);

    localparam int CMD_W = 1 + WAY_W + wtm_pkg::KEY_W;

    logic             push_valid, push_ready;
    logic [CMD_W-1:0] push_data;
    logic             cmd_valid, cmd_ready;
    logic [CMD_W-1:0] cmd_data;

    wtm_front #(
        .NUM_WAYS (NUM_WAYS)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .way        (way),
        .key        (key),
        .run_ended  (run_ended),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    wtm_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd_data)
    );

    wtm_back #(
        .NUM_WAYS (NUM_WAYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_data     (cmd_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .winner_key   (winner_key),
        .winner_way   (winner_way),
        .done_res     (done_res)
    );

endmodule
